// File: rtl/core/dtq_pkg.sv
`default_nettype none

package dtq_pkg;

  localparam int CH_W    = 8;
  localparam int VALUE_W = 15;
  localparam int IPART_W = 7;
  localparam int INT_W   = 10;
  localparam int FRAC_W  = 14;
  localparam int FBITS_W = 8;

  localparam logic [1:0] PH_INT  = 2'd0;
  localparam logic [1:0] PH_FRAC = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  localparam logic [CH_W-1:0] CH_NUL  = 8'h00;
  localparam logic [CH_W-1:0] CH_DOT  = 8'h2E;
  localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE = 8'h39;

  localparam logic [INT_W-1:0] INT_LIMIT = 10'd127;
  localparam logic [1:0] MAX_DIGITS = 2'd3;

  localparam logic [FBITS_W-1:0][FRAC_W-1:0] BIT_WEIGHT = {
    14'd39, 14'd78, 14'd156, 14'd312, 14'd625, 14'd1250, 14'd2500, 14'd5000
  };

  typedef struct packed {
    logic [IPART_W-1:0] int_part;
    logic [FRAC_W-1:0]  frac;
    logic               err;
  } num_t;

  function automatic logic [FBITS_W-1:0] frac_to_bits(input logic [FRAC_W-1:0] f);
    logic [FRAC_W-1:0]  r;
    logic [FBITS_W-1:0] bits;
    r    = f;
    bits = '0;
    for (int k = 0; k < FBITS_W; k++) begin
      if (r >= BIT_WEIGHT[k]) begin
        bits[FBITS_W-1-k] = 1'b1;
        r = r - BIT_WEIGHT[k];
      end
    end
    return bits;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/dtq_parse.sv
`default_nettype none

module dtq_parse (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   take,
  input  wire logic [dtq_pkg::CH_W-1:0] ch,
  output dtq_pkg::num_t               res
);
  import dtq_pkg::*;

  logic [1:0]        phase, phase_next;
  logic [1:0]        digit_count, digit_count_next;
  logic [INT_W-1:0]  int_accum, int_accum_next;
  logic [FRAC_W-1:0] frac_accum, frac_accum_next;
  logic              held_error, held_error_next;

  logic              is_digit;
  logic [3:0]        d;
  logic [FRAC_W-1:0] place;
  logic [FRAC_W-1:0] frac_add;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign d        = ch[3:0];

  always_comb begin
    case (digit_count)
      2'd0:    place = 14'd1000;
      2'd1:    place = 14'd100;
      2'd2:    place = 14'd10;
      default: place = 14'd0;
    endcase
  end

  assign frac_add = FRAC_W'({10'd0, d} * place);

  always_comb begin
    res.int_part = int_accum[IPART_W-1:0];
    res.frac     = frac_accum;
    case (phase)
      PH_INT:  res.err = (int_accum > INT_LIMIT);
      PH_FRAC: res.err = 1'b0;
      default: res.err = held_error;
    endcase
  end

  always_comb begin
    phase_next       = phase;
    digit_count_next = digit_count;
    int_accum_next   = int_accum;
    frac_accum_next  = frac_accum;
    held_error_next  = held_error;
    if (take) begin
      if (ch == CH_NUL) begin
        phase_next       = PH_INT;
        digit_count_next = 2'd0;
        int_accum_next   = '0;
        frac_accum_next  = '0;
        held_error_next  = 1'b0;
      end else begin
        case (phase)
          PH_INT: begin
            if (is_digit) begin
              if (digit_count >= MAX_DIGITS) begin
                phase_next      = PH_DONE;
                held_error_next = 1'b1;
              end else begin
                int_accum_next   = INT_W'({int_accum, 3'b000} + {int_accum, 1'b0} + {6'd0, d});
                digit_count_next = digit_count + 2'd1;
              end
            end else if (ch == CH_DOT) begin
              if (int_accum > INT_LIMIT) begin
                phase_next      = PH_DONE;
                held_error_next = 1'b1;
              end else begin
                phase_next       = PH_FRAC;
                digit_count_next = 2'd0;
              end
            end else begin
              phase_next      = PH_DONE;
              held_error_next = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit && (digit_count < MAX_DIGITS)) begin
              frac_accum_next  = frac_accum + frac_add;
              digit_count_next = digit_count + 2'd1;
              if (digit_count_next == MAX_DIGITS) begin
                phase_next      = PH_DONE;
                held_error_next = 1'b0;
              end
            end else begin
              phase_next      = PH_DONE;
              held_error_next = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_INT;
      digit_count <= 2'd0;
      int_accum   <= '0;
      frac_accum  <= '0;
      held_error  <= 1'b0;
    end else begin
      phase       <= phase_next;
      digit_count <= digit_count_next;
      int_accum   <= int_accum_next;
      frac_accum  <= frac_accum_next;
      held_error  <= held_error_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/decimal_text_to_q8_8_top.sv
// Parses a NUL-terminated decimal string of the form iii[.ddd], one character per
// transaction, into an unsigned 7.8 fixed point value; a character is taken every
// cycle unless the result side backs up, and each NUL yields one result transaction
// through a register that captures the parsed parts and then one that converts the
// fraction to bits and registers the result, while all other characters yield none.
// Malformed strings, more than three integer digits or an integer part above 127
// give value 0 with error set; characters after a decided result are dropped.
`default_nettype none

module decimal_text_to_q8_8_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      char_valid,
  output logic                           char_stall,
  input  wire logic [dtq_pkg::CH_W-1:0]  ch,
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output logic [dtq_pkg::VALUE_W-1:0]    value,
  output logic                           error
);
  import dtq_pkg::*;

  logic take;
  logic o_ready;
  logic b_ready;
  logic b_valid;
  num_t b_num;
  num_t res;

  assign o_ready    = !result_valid || !result_stall;
  assign b_ready    = !b_valid || o_ready;
  assign char_stall = !b_ready;
  assign take       = char_valid && b_ready;

  dtq_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .ch   (ch),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= take && (ch == CH_NUL);
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_num <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (o_ready) begin
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      error <= b_num.err;
      if (b_num.err) begin
        value <= '0;
      end else begin
        value <= {b_num.int_part, frac_to_bits(b_num.frac)};
      end
    end
  end

endmodule

`default_nettype wire

// File: sim/dtq_result_checker.sv
`default_nettype none

module dtq_result_checker
  import dtq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               char_valid,
  input  wire logic               char_stall,
  input  wire logic [CH_W-1:0]    ch,
  input  wire logic               result_valid,
  input  wire logic               result_stall,
  input  wire logic [VALUE_W-1:0] value,
  input  wire logic               error,
  output int                      mismatches,
  output int                      pending
);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
  } q88_result_t;

  q88_result_t        expected_q88[$];
  logic [1:0]         phase;
  logic [1:0]         digit_count;
  logic [INT_W-1:0]   int_part;
  logic [FRAC_W-1:0]  frac_part;
  q88_result_t        held;

  function automatic logic [FBITS_W-1:0] frac_bits(input logic [FRAC_W-1:0] f);
    int                 rest;
    logic [FBITS_W-1:0] bits;
    rest = int'(f);
    bits = '0;
    for (int k = 0; k < FBITS_W; k++) begin
      if (rest >= (10000 >> (k + 1))) begin
        bits[FBITS_W-1-k] = 1'b1;
        rest = rest - (10000 >> (k + 1));
      end
    end
    return bits;
  endfunction

  function automatic logic [VALUE_W-1:0] pack_q88(input logic [INT_W-1:0] ip,
                                                   input logic [FRAC_W-1:0] fp);
    return {ip[IPART_W-1:0], frac_bits(fp)};
  endfunction

  task automatic clear_parse();
    phase       = PH_INT;
    digit_count = '0;
    int_part    = '0;
    frac_part   = '0;
    held        = '0;
  endtask

  task automatic settle(input logic [VALUE_W-1:0] v, input logic e);
    held.value = v;
    held.error = e;
    phase      = PH_DONE;
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 100) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
    mismatches++;
  endtask

  task automatic absorb_char(input logic [CH_W-1:0] c);
    logic        is_digit;
    int          d;
    q88_result_t r;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d = is_digit ? int'(c - CH_ZERO) : 0;
    if (c == CH_NUL) begin
      case (phase)
        PH_INT: begin
          if (int_part > INT_LIMIT) begin
            r.value = '0;
            r.error = 1'b1;
          end else begin
            r.value = pack_q88(int_part, '0);
            r.error = 1'b0;
          end
        end
        PH_FRAC: begin
          r.value = pack_q88(int_part, frac_part);
          r.error = 1'b0;
        end
        default: begin
          r = held;
        end
      endcase
      expected_q88.push_back(r);
      clear_parse();
    end else begin
      case (phase)
        PH_INT: begin
          if (is_digit) begin
            if (digit_count == MAX_DIGITS) begin
              settle('0, 1'b1);
            end else begin
              int_part = INT_W'(int_part * 10 + d);
              digit_count++;
            end
          end else if (c == CH_DOT) begin
            if (int_part > INT_LIMIT) begin
              settle('0, 1'b1);
            end else begin
              phase       = PH_FRAC;
              digit_count = '0;
            end
          end else begin
            settle('0, 1'b1);
          end
        end
        PH_FRAC: begin
          if (is_digit && digit_count < MAX_DIGITS) begin
            case (digit_count)
              2'd0: frac_part = FRAC_W'(frac_part + 1000 * d);
              2'd1: frac_part = FRAC_W'(frac_part + 100 * d);
              default: frac_part = FRAC_W'(frac_part + 10 * d);
            endcase
            digit_count++;
            if (digit_count == MAX_DIGITS) begin
              settle(pack_q88(int_part, frac_part), 1'b0);
            end
          end else begin
            settle('0, 1'b1);
          end
        end
        default: begin
        end
      endcase
    end
  endtask

  task automatic check_result(input logic [VALUE_W-1:0] v, input logic e);
    q88_result_t want;
    if (expected_q88.size() == 0) begin
      report_mismatch($sformatf("unexpected result value=%0d error=%0b", v, e));
    end else begin
      want = expected_q88.pop_front();
      if (v !== want.value) begin
        report_mismatch($sformatf("value %0d, expected %0d", v, want.value));
      end
      if (e !== want.error) begin
        report_mismatch($sformatf("error %0b, expected %0b", e, want.error));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_parse();
      expected_q88.delete();
      mismatches = 0;
    end else begin
      if (result_valid && !result_stall) begin
        check_result(value, error);
      end
      if (char_valid && !char_stall) begin
        absorb_char(ch);
      end
    end
    pending <= expected_q88.size();
  end

endmodule

`default_nettype wire

// File: sim/decimal_text_to_q8_8_top_tb.sv
`default_nettype none

module decimal_text_to_q8_8_top_tb;
  import dtq_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int TOTAL_CHARS = 1950;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                char_valid = 1'b0;
  logic [CH_W-1:0]     ch = '0;
  logic                result_stall = 1'b0;
  wire logic           char_stall;
  wire logic           result_valid;
  wire logic [VALUE_W-1:0] value;
  wire logic           error;
  int                  mismatches;
  int                  pending;
  int                  chars_sent = 0;
  int                  tx_idle_pct = 23;
  int                  rx_idle_pct = 56;

  always #1 clk = ~clk;

  decimal_text_to_q8_8_top dut (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .ch           (ch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .error        (error)
  );

  dtq_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .ch           (ch),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .value        (value),
    .error        (error),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  always @(posedge clk) begin
    result_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  task automatic send_char(input logic [CH_W-1:0] c);
    while ($urandom_range(99) < tx_idle_pct) begin
      char_valid <= 1'b0;
      @(posedge clk);
    end
    char_valid <= 1'b1;
    ch         <= c;
    @(posedge clk);
    while (char_stall) begin
      @(posedge clk);
    end
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i]);
    end
    send_char(CH_NUL);
  endtask

  task automatic drain_results();
    char_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [CH_W-1:0] digit_char(input int d);
    return CH_ZERO + d[3:0];
  endfunction

  function automatic logic [CH_W-1:0] noise_char();
    int pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return digit_char($urandom_range(9));
    end else if (pick < 6) begin
      return CH_DOT;
    end
    return CH_W'($urandom_range(1, 255));
  endfunction

  task automatic send_random_string();
    int mode;
    int n_int;
    int n_frac;
    int ival;
    mode = $urandom_range(99);
    if (mode < 78) begin
      n_int = $urandom_range(3);
      if (n_int == 3) begin
        ival = ($urandom_range(99) < 80) ? $urandom_range(127) : $urandom_range(128, 999);
        send_char(digit_char(ival / 100));
        send_char(digit_char((ival / 10) % 10));
        send_char(digit_char(ival % 10));
      end else begin
        for (int i = 0; i < n_int; i++) begin
          send_char(digit_char($urandom_range(9)));
        end
      end
      if ($urandom_range(99) < 75) begin
        send_char(CH_DOT);
        n_frac = $urandom_range(4);
        for (int i = 0; i < n_frac; i++) begin
          send_char(digit_char($urandom_range(9)));
        end
        if (n_frac == 3 && $urandom_range(99) < 30) begin
          send_char(CH_W'($urandom_range(1, 255)));
        end
      end
      if ($urandom_range(99) < 8) begin
        send_char(noise_char());
      end
    end else begin
      n_int = $urandom_range(7);
      for (int i = 0; i < n_int; i++) begin
        send_char(noise_char());
      end
    end
    send_char(CH_NUL);
  endtask

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (char_valid && !char_stall) || (result_valid && !result_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_text("");
    send_text("0");
    send_text("127");
    send_text("128");
    send_text("1234");
    send_text("5.");
    send_text(".5");
    send_text(".");
    send_text("127.999");
    send_text("0.0625");
    send_text("12a");
    send_text("1.2.3");
    send_text("200.5");
    send_text("3.x");
    send_char(8'hFF);
    send_char(CH_NUL);
    send_char(digit_char(9));
    send_char(8'h80);
    send_char(CH_NUL);

    while (chars_sent < TOTAL_CHARS / 3) begin
      send_random_string();
    end
    drain_results();
    tx_idle_pct = 56;
    rx_idle_pct = 23;
    while (chars_sent < 2 * TOTAL_CHARS / 3) begin
      send_random_string();
    end
    drain_results();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (chars_sent < TOTAL_CHARS) begin
      send_random_string();
    end
    drain_results();
    repeat (20) @(posedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/core/dtq_pkg.sv
rtl/core/dtq_parse.sv
rtl/core/decimal_text_to_q8_8_top.sv
sim/dtq_result_checker.sv
sim/decimal_text_to_q8_8_top_tb.sv
